// ----- rtl/core/sv39ptw_pkg.sv -----
// sv39ptw_pkg: shared types and constants for the sv39 page table walker
// no dependencies; imported by sv39_page_table_walker
`timescale 1ns / 1ps

package sv39ptw_pkg;

  // field widths
  localparam int unsigned VA_W    = 39;
  localparam int unsigned PTE_W   = 64;
  localparam int unsigned ADDR_W  = 56;
  localparam int unsigned PPN_W   = 44;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned VPN_W   = 9;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 44;

  // satp mode code for sv39
  localparam logic [MODE_W-1:0] MODE_SV39 = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 2'd1;

  // input action codes
  localparam logic ACT_REQUEST  = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  // walk levels
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MID = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd0;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  // fault codes
  typedef enum logic [2:0] {
    FAULT_NONE       = 3'd0,
    FAULT_MODE       = 3'd1,
    FAULT_INVALID    = 3'd2,
    FAULT_ZERO_TABLE = 3'd3,
    FAULT_NO_LEAF    = 3'd4
  } fault_t;

endpackage

// ----- rtl/core/sv39_page_table_walker.sv -----
// sv39_page_table_walker: three-level sv39 walk, one item per cycle while in_ready is high
// depends on sv39ptw_pkg for widths, result kinds and fault codes
// The result of an accepted item, if it yields one, is registered in the output register.
// Throughput: one item per cycle unless the output stalls; each entry is decoded
// by shifts and masks only; the walk state and result register update on acceptance.
// in_ready stays high while the output register is empty or being taken.
// Reset (synchronous, active low) clears the walk state, both config
// registers and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps

module sv39_page_table_walker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_action,
  input  logic [sv39ptw_pkg::VA_W-1:0]           in_virtual_address,
  input  logic [sv39ptw_pkg::PTE_W-1:0]          in_entry_data,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             out_result_kind,
  output logic [sv39ptw_pkg::ADDR_W-1:0]         out_address,
  output logic [2:0]                             out_fault_code
);

  import sv39ptw_pkg::*;

  // configuration registers
  logic [MODE_W-1:0]  mode_r;
  logic [PPN_W-1:0]   root_r;

  // walk state
  logic               busy_r, busy_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [VA_W-1:0]    pend_r, pend_nxt;

  // output register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [ADDR_W-1:0]  out_addr_r;
  fault_t             out_fault_r;

  // result of the item being accepted
  logic               res_emit;
  kind_t              res_kind;
  logic [ADDR_W-1:0]  res_addr;
  fault_t             res_fault;

  logic               in_fire;
  logic               pte_valid, pte_leaf;
  logic [PPN_W-1:0]   next_page;
  logic [PPN_W-1:0]   req_page;
  logic [LEVEL_W-1:0] req_level;
  logic [VA_W-1:0]    req_va;
  logic [VPN_W-1:0]   req_vpn;
  logic [ADDR_W-1:0]  req_addr;
  logic [ADDR_W-1:0]  leaf_pa;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // entry decode
  assign pte_valid = in_entry_data[0];
  assign pte_leaf  = pte_valid && (in_entry_data[1] || in_entry_data[3]);
  assign next_page = in_entry_data[53:10];

  // translated address of a leaf at the current level
  always_comb begin
    unique case (level_r)
      LEVEL_TOP: leaf_pa = {in_entry_data[53:28], pend_r[29:0]};
      LEVEL_MID: leaf_pa = {in_entry_data[53:19], pend_r[20:0]};
      default:   leaf_pa = {in_entry_data[53:10], pend_r[11:0]};
    endcase
  end

  // entry read address: table page plus eight times the vpn of the level
  always_comb begin
    unique case (req_level)
      LEVEL_TOP: req_vpn = req_va[38:30];
      LEVEL_MID: req_vpn = req_va[29:21];
      default:   req_vpn = req_va[20:12];
    endcase
  end
  assign req_addr = {req_page, req_vpn, 3'b000};

  // walk step
  always_comb begin
    busy_nxt  = busy_r;
    level_nxt = level_r;
    pend_nxt  = pend_r;
    res_emit  = 1'b0;
    res_kind  = KIND_READ;
    res_addr  = '0;
    res_fault = FAULT_NONE;
    req_page  = root_r;
    req_level = LEVEL_TOP;
    req_va    = in_virtual_address;
    if (in_action == ACT_REQUEST) begin
      // new request abandons any walk in progress
      pend_nxt  = in_virtual_address;
      level_nxt = LEVEL_TOP;
      busy_nxt  = 1'b0;
      res_emit  = 1'b1;
      priority if (mode_r != MODE_SV39) begin
        res_kind  = KIND_FAULT;
        res_fault = FAULT_MODE;
      end else if (root_r == '0) begin
        res_kind  = KIND_FAULT;
        res_fault = FAULT_ZERO_TABLE;
      end else begin
        busy_nxt = 1'b1;
        res_addr = req_addr;
      end
    end else if (busy_r) begin
      // response to an outstanding read
      res_emit  = 1'b1;
      busy_nxt  = 1'b0;
      req_page  = next_page;
      req_level = level_r - 2'd1;
      req_va    = pend_r;
      priority if (pte_leaf) begin
        res_kind = KIND_DONE;
        res_addr = leaf_pa;
      end else if (!pte_valid) begin
        res_kind  = KIND_FAULT;
        res_fault = FAULT_INVALID;
      end else if (level_r == LEVEL_LOW) begin
        res_kind  = KIND_FAULT;
        res_fault = FAULT_NO_LEAF;
      end else if (next_page == '0) begin
        res_kind  = KIND_FAULT;
        res_fault = FAULT_ZERO_TABLE;
      end else begin
        busy_nxt  = 1'b1;
        level_nxt = level_r - 2'd1;
        res_addr  = req_addr;
      end
    end
  end

  // configuration, walk state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      root_r      <= '0;
      busy_r      <= 1'b0;
      level_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODE) begin
          mode_r <= cfg_data[MODE_W-1:0];
        end else if (cfg_index == CFG_ROOT) begin
          root_r <= cfg_data[PPN_W-1:0];
        end
      end
      if (in_fire) begin
        busy_r  <= busy_nxt;
        level_r <= level_nxt;
        pend_r  <= pend_nxt;
      end
      if (in_fire && res_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && res_emit) begin
      out_kind_r  <= res_kind;
      out_addr_r  <= res_addr;
      out_fault_r <= res_fault;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_address     = out_addr_r;
  assign out_fault_code  = out_fault_r;

`ifndef SYNTH
  // a fault result carries a zero address
  a_fault_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_FAULT) |-> (out_addr_r == '0))
    else $error("fault result with nonzero address");

  // read and done results carry no fault code
  a_ok_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_FAULT) |-> (out_fault_r == FAULT_NONE))
    else $error("non-fault result with fault code");

  // issuing a read leaves the walker busy
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_emit && res_kind == KIND_READ) |=> busy_r)
    else $error("read issued but walker idle");

  // a response while idle into a drained output produces no result
  a_idle_resp_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_RESPONSE && !busy_r && !out_valid_r) |=> !out_valid_r)
    else $error("result from response while idle");

  // the walk level never leaves the three sv39 levels
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (level_r == LEVEL_TOP || level_r == LEVEL_MID || level_r == LEVEL_LOW))
    else $error("walk level out of range");
`endif

endmodule
